>>> rtl/core/assert_macros.svh
// Assertion macros shared by the decoder RTL.
// Included by files that carry concurrent checks; needs clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Condition in one cycle implies a consequence in the next cycle.
`define ASSERT_NEXT(label, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/b64d_pkg.sv
// Types, constants and the alphabet lookup for the base64 decoder.
// No dependencies; used by all decoder modules.
package b64d_pkg;

  localparam int QUEUE_DEPTH = 2;
  localparam int POS_W       = 5;
  localparam int ACC_W       = 18;
  localparam int VALUE_W     = 128;
  localparam int MAX_BYTES   = 16;

  localparam logic [7:0] CHAR_PAD = 8'h3d;  // '='

  typedef enum logic [1:0] {
    KIND_SKIP   = 2'd0,
    KIND_SEXTET = 2'd1,
    KIND_PAD    = 2'd2
  } b64d_kind_t;

  typedef struct packed {
    b64d_kind_t  kind;
    logic [5:0]  sextet;
    logic        last;
  } b64d_item_t;

  // {hit, sextet}; hit low for characters outside the alphabet
  function automatic logic [6:0] sextet_of(input logic [7:0] ch);
    logic [7:0] d;
    d = 8'd0;
    if (ch >= 8'h41 && ch <= 8'h5a) begin
      d = ch - 8'h41;
      return {1'b1, d[5:0]};
    end else if (ch >= 8'h61 && ch <= 8'h7a) begin
      d = ch - 8'h61 + 8'd26;
      return {1'b1, d[5:0]};
    end else if (ch >= 8'h30 && ch <= 8'h39) begin
      d = ch - 8'h30 + 8'd52;
      return {1'b1, d[5:0]};
    end else if (ch == 8'h2b) begin
      return {1'b1, 6'd62};
    end else if (ch == 8'h2f) begin
      return {1'b1, 6'd63};
    end
    return 7'd0;
  endfunction

endpackage

>>> rtl/core/b64d_front.sv
// Front end: accepts characters, classifies them against the alphabet.
// Depends on b64d_pkg; feeds b64d_queue.
`include "assert_macros.svh"
module b64d_front import b64d_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_char_code,
  input  logic       in_char_present,
  input  logic       in_last,
  input  logic       q_full,
  output logic       q_push,
  output b64d_item_t q_item
);

  logic [6:0] lookup;
  b64d_kind_t kind;
  logic       xfer;

  assign lookup = sextet_of(in_char_code);

  always_comb begin
    kind = KIND_SKIP;
    if (in_char_present) begin
      if (in_char_code == CHAR_PAD) begin
        kind = KIND_PAD;
      end else if (lookup[6]) begin
        kind = KIND_SEXTET;
      end
    end
  end

  assign in_ready = !q_full;
  assign xfer     = in_valid && in_ready;

  // skipped characters that do not end the string need no further work
  assign q_push        = xfer && (in_last || kind != KIND_SKIP);
  assign q_item.kind   = kind;
  assign q_item.sextet = lookup[5:0];
  assign q_item.last   = in_last;

  `ASSERT_ALWAYS(a_front_no_push_full, !(q_push && q_full),
                 "front pushed into full queue")

endmodule

>>> rtl/core/b64d_queue.sv
// Short item queue between front and back of the decoder.
// Depends on b64d_pkg for the item type and depth.
`include "assert_macros.svh"
module b64d_queue import b64d_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  b64d_item_t push_item,
  output logic       full,
  input  logic       pop,
  output logic       head_valid,
  output b64d_item_t head_item
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  b64d_item_t         entry_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;

  assign full       = (cnt_r == CNT_W'(QUEUE_DEPTH));
  assign head_valid = (cnt_r != '0);
  assign head_item  = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_item;
    end
  end

  `ASSERT_ALWAYS(a_queue_cnt_bound, cnt_r <= CNT_W'(QUEUE_DEPTH),
                 "queue count above depth")
  `ASSERT_ALWAYS(a_queue_pop_nonempty, !pop || head_valid,
                 "pop from empty queue")

endmodule

>>> rtl/core/b64d_back.sv
// Back end: sextet accumulation, byte store update, flush and result register.
// Depends on b64d_pkg; drains b64d_queue.
`include "assert_macros.svh"
module b64d_back import b64d_pkg::*; #(
  parameter int VALUE_BYTES = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               head_valid,
  input  b64d_item_t         head_item,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [63:0]        out_value_low,
  output logic [63:0]        out_value_high,
  output logic [POS_W-1:0]   out_bytes_decoded,
  output logic               out_overflow
);

  localparam logic [POS_W:0]   VB_SUM = (POS_W+1)'(VALUE_BYTES);
  localparam logic [POS_W-1:0] VB_POS = POS_W'(VALUE_BYTES);

  logic [7:0]        store_r [VALUE_BYTES];
  logic [7:0]        store_nxt [VALUE_BYTES];
  logic [ACC_W-1:0]  acc_r, acc_c;
  logic [1:0]        cnt_r, cnt_c;
  logic [POS_W-1:0]  pos_r, pos_c;
  logic              pad_r, pad_c;
  logic              ovf_r, ovf_c;

  logic              out_valid_r, out_valid_nxt;
  logic [VALUE_W-1:0] value_r, value_nxt;
  logic [POS_W-1:0]  count_r;
  logic              oflag_r;

  logic [23:0]       word;
  logic [7:0]        b0, b1, b2;
  logic [1:0]        nb;
  logic [POS_W:0]    sum;
  logic              done;

  assign pop  = head_valid && (!head_item.last || !out_valid_r || out_ready);
  assign done = pop && head_item.last;
  assign word = {acc_r, head_item.sextet};

  // character step, then leftover flush when the string ends
  always_comb begin
    acc_c = acc_r;
    cnt_c = cnt_r;
    pad_c = pad_r;
    b0 = word[23:16];
    b1 = word[15:8];
    b2 = word[7:0];
    nb = 2'd0;
    if (!pad_r && head_item.kind == KIND_PAD) begin
      pad_c = 1'b1;
    end else if (!pad_r && head_item.kind == KIND_SEXTET) begin
      if (cnt_r == 2'd3) begin
        nb    = 2'd3;
        acc_c = '0;
        cnt_c = 2'd0;
      end else begin
        acc_c = {acc_r[11:0], head_item.sextet};
        cnt_c = cnt_r + 2'd1;
      end
    end
    if (head_item.last) begin
      if (cnt_c == 2'd2) begin
        b0 = acc_c[11:4];
        nb = 2'd1;
      end else if (cnt_c == 2'd3) begin
        b0 = acc_c[17:10];
        b1 = acc_c[9:2];
        nb = 2'd2;
      end
    end
  end

  assign sum   = {1'b0, pos_r} + {{(POS_W-1){1'b0}}, nb};
  assign pos_c = (sum > VB_SUM) ? VB_POS : sum[POS_W-1:0];
  assign ovf_c = ovf_r || (sum > VB_SUM);

  always_comb begin
    for (int i = 0; i < VALUE_BYTES; i++) begin
      store_nxt[i] = store_r[i];
      if (nb > 2'd0 && {1'b0, pos_r} == (POS_W+1)'(i)) begin
        store_nxt[i] = b0;
      end
      if (nb > 2'd1 && {1'b0, pos_r} + 1'b1 == (POS_W+1)'(i)) begin
        store_nxt[i] = b1;
      end
      if (nb > 2'd2 && {1'b0, pos_r} + 2'd2 == (POS_W+1)'(i)) begin
        store_nxt[i] = b2;
      end
    end
  end

  // slots past VALUE_BYTES read as zero
  always_comb begin
    value_nxt = '0;
    for (int i = 0; i < VALUE_BYTES; i++) begin
      value_nxt[8*i +: 8] = store_nxt[i];
    end
  end

  assign out_valid_nxt = done ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n || done) begin
      acc_r <= '0;
      cnt_r <= '0;
      pos_r <= '0;
      pad_r <= 1'b0;
      ovf_r <= 1'b0;
      for (int i = 0; i < VALUE_BYTES; i++) begin
        store_r[i] <= '0;
      end
    end else if (pop) begin
      acc_r <= acc_c;
      cnt_r <= cnt_c;
      pos_r <= pos_c;
      pad_r <= pad_c;
      ovf_r <= ovf_c;
      store_r <= store_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      value_r <= value_nxt;
      count_r <= pos_c;
      oflag_r <= ovf_c;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_value_low     = value_r[63:0];
  assign out_value_high    = value_r[127:64];
  assign out_bytes_decoded = count_r;
  assign out_overflow      = oflag_r;

  `ASSERT_ALWAYS(a_back_pos_bound, pos_r <= VB_POS, "byte position past value size")
  `ASSERT_NEXT(a_back_clear_after_result, done,
               pos_r == '0 && cnt_r == 2'd0 && !pad_r && !ovf_r && out_valid_r,
               "state not cleared after result")

endmodule

>>> rtl/core/base64_to_128bit_decoder_unit.sv
// Top level of the base64 to 128-bit decoder.
// Depends on b64d_pkg, b64d_front, b64d_queue and b64d_back.

// Takes one base64 character per input transfer and returns one 128-bit value
// (bytes little-endian, first decoded byte in bits 7:0) after the transfer
// flagged last. Characters outside the standard alphabet and codes at or above
// 128 are skipped; '=' ends decoding for the rest of the string. Bytes past
// VALUE_BYTES are dropped and flagged in out_overflow. Sustained rate is one
// character per clock while no result is stalled: the back end retires one
// queued character per cycle, including the four-sextet-to-three-byte write,
// but holds a string's last character while the previous result is unread.
// A result is valid once its last character is retired from the queue.
// A two-entry queue separates input acceptance from the back end, so a stalled
// result holds off new input only once the queue fills.
module base64_to_128bit_decoder_unit import b64d_pkg::*; #(
  parameter int VALUE_BYTES = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [7:0]       in_char_code,
  input  logic             in_char_present,
  input  logic             in_last,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [63:0]      out_value_low,
  output logic [63:0]      out_value_high,
  output logic [POS_W-1:0] out_bytes_decoded,
  output logic             out_overflow
);

  logic       q_full;
  logic       q_push;
  b64d_item_t q_item;
  logic       q_pop;
  logic       q_valid;
  b64d_item_t q_head;

  b64d_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_char_code    (in_char_code),
    .in_char_present (in_char_present),
    .in_last         (in_last),
    .q_full          (q_full),
    .q_push          (q_push),
    .q_item          (q_item)
  );

  b64d_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_item  (q_item),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_item  (q_head)
  );

  b64d_back #(
    .VALUE_BYTES (VALUE_BYTES)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .head_valid        (q_valid),
    .head_item         (q_head),
    .pop               (q_pop),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_value_low     (out_value_low),
    .out_value_high    (out_value_high),
    .out_bytes_decoded (out_bytes_decoded),
    .out_overflow      (out_overflow)
  );

endmodule

>>> tb/b64_decode_checker.sv
// Checker for the base64 to 128-bit decoder: watches both channels, predicts each value.
// Depends on b64d_pkg for widths and the pad character.
module b64_decode_checker import b64d_pkg::*; #(
  parameter int VALUE_BYTES = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_ready,
  input  logic [7:0]       in_char_code,
  input  logic             in_char_present,
  input  logic             in_last,
  input  logic             out_valid,
  input  logic             out_ready,
  input  logic [63:0]      out_value_low,
  input  logic [63:0]      out_value_high,
  input  logic [POS_W-1:0] out_bytes_decoded,
  input  logic             out_overflow,
  output int               fail_count,
  output int               pending,
  output int               values_checked,
  output int               overflow_values
);

  typedef struct packed {
    logic [63:0]      lo;
    logic [63:0]      hi;
    logic [POS_W-1:0] nbytes;
    logic             ovf;
  } decoded_value_t;

  logic [7:0]       byte_slot [MAX_BYTES];
  logic [ACC_W-1:0] acc;
  logic [1:0]       nsext;
  logic [POS_W-1:0] wr_pos;
  logic             pad_hit;
  logic             ovf_hit;

  decoded_value_t expected_values [$];
  int mismatches = 0;
  int checked    = 0;
  int ovf_count  = 0;

  // 8'hff flags a character outside the alphabet
  function automatic logic [7:0] alphabet_index(input logic [7:0] ch);
    logic [7:0] k;
    k = 8'hff;
    if (ch >= "A" && ch <= "Z") k = ch - "A";
    else if (ch >= "a" && ch <= "z") k = ch - "a" + 8'd26;
    else if (ch >= "0" && ch <= "9") k = ch - "0" + 8'd52;
    else if (ch == "+") k = 8'd62;
    else if (ch == "/") k = 8'd63;
    return k;
  endfunction

  task automatic clear_decode_state();
    for (int i = 0; i < MAX_BYTES; i++) byte_slot[i] = 8'd0;
    acc     = '0;
    nsext   = 2'd0;
    wr_pos  = '0;
    pad_hit = 1'b0;
    ovf_hit = 1'b0;
  endtask

  task automatic put_byte(input logic [7:0] b);
    if (wr_pos < VALUE_BYTES) begin
      byte_slot[wr_pos[$clog2(MAX_BYTES)-1:0]] = b;
      wr_pos = wr_pos + 1'b1;
    end else begin
      ovf_hit = 1'b1;
    end
  endtask

  task automatic decode_char(input logic [7:0] ch);
    logic [7:0]  s;
    logic [23:0] word;
    s = alphabet_index(ch);
    if (!pad_hit) begin
      if (ch == CHAR_PAD) begin
        pad_hit = 1'b1;
      end else if (s != 8'hff) begin
        if (nsext == 2'd3) begin
          word = {acc, s[5:0]};
          put_byte(word[23:16]);
          put_byte(word[15:8]);
          put_byte(word[7:0]);
          acc   = '0;
          nsext = 2'd0;
        end else begin
          acc   = {acc[11:0], s[5:0]};
          nsext = nsext + 2'd1;
        end
      end
    end
  endtask

  task automatic finish_value();
    decoded_value_t v;
    // leftover sextets: two give one byte, three give two, one is lost
    if (nsext == 2'd2) begin
      put_byte(acc[11:4]);
    end else if (nsext == 2'd3) begin
      put_byte(acc[17:10]);
      put_byte(acc[9:2]);
    end
    for (int k = 0; k < 8; k++) begin
      v.lo[8*k +: 8] = byte_slot[k];
      v.hi[8*k +: 8] = byte_slot[k+8];
    end
    v.nbytes = wr_pos;
    v.ovf    = ovf_hit;
    expected_values.push_back(v);
    clear_decode_state();
  endtask

  task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
    if (got !== want) begin
      if (mismatches < 10)
        $display("[%0t] %s: expected %h, got %h", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : watch
    decoded_value_t want;
    if (!rst_n) begin
      clear_decode_state();
      expected_values.delete();
    end else begin
      // results leave only after their last character has been accepted, so pop first
      if (out_valid && out_ready) begin
        if (expected_values.size() == 0) begin
          if (mismatches < 10)
            $display("[%0t] value with nothing expected: low %h high %h bytes %0d ovf %b",
                     $time, out_value_low, out_value_high, out_bytes_decoded, out_overflow);
          mismatches++;
        end else begin
          want = expected_values.pop_front();
          check_field("value_low", want.lo, out_value_low);
          check_field("value_high", want.hi, out_value_high);
          check_field("bytes_decoded", 64'(want.nbytes), 64'(out_bytes_decoded));
          check_field("overflow", 64'(want.ovf), 64'(out_overflow));
          checked++;
          if (want.ovf) ovf_count++;
        end
      end
      if (in_valid && in_ready) begin
        if (in_char_present) decode_char(in_char_code);
        if (in_last) finish_value();
      end
    end
    pending         <= expected_values.size();
    fail_count      <= mismatches;
    values_checked  <= checked;
    overflow_values <= ovf_count;
  end

endmodule

>>> tb/tb_base64_to_128bit_decoder_unit.sv
// Testbench top for base64_to_128bit_decoder_unit: drives strings, stalls the result side.
// Depends on b64d_pkg, the decoder RTL and b64_decode_checker.
module tb_base64_to_128bit_decoder_unit;
  import b64d_pkg::*;

  localparam int STALL_LIMIT = 2000;

  logic             clk;
  logic             rst_n;
  logic             in_valid;
  logic             in_ready;
  logic [7:0]       in_char_code;
  logic             in_char_present;
  logic             in_last;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic [63:0]      out_value_low;
  logic [63:0]      out_value_high;
  logic [POS_W-1:0] out_bytes_decoded;
  logic             out_overflow;

  int fail_count;
  int pending;
  int values_checked;
  int overflow_values;

  int items_sent   = 0;
  int strings_sent = 0;
  int quiet_cycles = 0;
  int stall_left   = 0;
  logic steady     = 1'b0;

  base64_to_128bit_decoder_unit dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_char_code      (in_char_code),
    .in_char_present   (in_char_present),
    .in_last           (in_last),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_value_low     (out_value_low),
    .out_value_high    (out_value_high),
    .out_bytes_decoded (out_bytes_decoded),
    .out_overflow      (out_overflow)
  );

  b64_decode_checker checker_i (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_char_code      (in_char_code),
    .in_char_present   (in_char_present),
    .in_last           (in_last),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_value_low     (out_value_low),
    .out_value_high    (out_value_high),
    .out_bytes_decoded (out_bytes_decoded),
    .out_overflow      (out_overflow),
    .fail_count        (fail_count),
    .pending           (pending),
    .values_checked    (values_checked),
    .overflow_values   (overflow_values)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // result side: short stall bursts, none started inside the steady window
  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!steady && $urandom_range(99) < 2) begin
      out_ready  <= 1'b0;
      stall_left <= $urandom_range(4);
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    wait (quiet_cycles >= STALL_LIMIT);
    $display("watchdog: no transfer for %0d cycles, %0d values pending", STALL_LIMIT, pending);
    $display("base64_to_128bit_decoder_unit: mismatch");
    $finish;
  end

  function automatic logic [7:0] b64_char(input logic [5:0] v);
    if (v < 6'd26) return "A" + v;
    if (v < 6'd52) return "a" + (v - 6'd26);
    if (v < 6'd62) return "0" + (v - 6'd52);
    if (v == 6'd62) return "+";
    return "/";
  endfunction

  // called at a rising edge; returns at the edge where the transfer happens
  task automatic send_item(input logic [7:0] code, input logic present, input logic last_flag);
    if (!steady && $urandom_range(99) < 2) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_char_code    <= code;
    in_char_present <= present;
    in_last         <= last_flag;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (present || last_flag) items_sent++;
    if (last_flag) strings_sent++;
  endtask

  task automatic send_string(input string s, input bit empty_end);
    for (int i = 0; i < s.len(); i++)
      send_item(s[i], 1'b1, !empty_end && i == s.len() - 1);
    if (empty_end) send_item(8'h00, 1'b0, 1'b1);
  endtask

  // checker's count is registered, so the loop waits on the clock before each test
  task automatic hold_until_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic send_random_string(input int n_sextets);
    logic [7:0] codes [$];
    logic       has_char [$];
    int         tail;
    for (int i = 0; i < n_sextets; i++) begin
      if ($urandom_range(99) < 8) begin
        codes.push_back(8'($urandom_range(255)));
        has_char.push_back(1'b1);
      end
      if ($urandom_range(99) < 3) begin
        codes.push_back(8'($urandom_range(255)));
        has_char.push_back(1'b0);
      end
      codes.push_back(b64_char(6'($urandom_range(63))));
      has_char.push_back(1'b1);
    end
    if ($urandom_range(99) < 80) begin
      tail = (4 - n_sextets % 4) % 4;
      repeat (tail) begin
        codes.push_back(CHAR_PAD);
        has_char.push_back(1'b1);
      end
    end
    // junk past the end of the encoding
    if ($urandom_range(99) < 10) begin
      repeat ($urandom_range(1, 4)) begin
        codes.push_back(($urandom_range(1) == 1) ? b64_char(6'($urandom_range(63)))
                                                 : 8'($urandom_range(255)));
        has_char.push_back(1'b1);
      end
    end
    if (codes.size() == 0 || $urandom_range(1) == 1) begin
      codes.push_back(8'($urandom_range(255)));
      has_char.push_back(1'b0);
    end
    for (int i = 0; i < codes.size(); i++)
      send_item(codes[i], has_char[i], i == codes.size() - 1);
  endtask

  initial begin
    clk             = 1'b0;
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_char_code    = 8'h00;
    in_char_present = 1'b0;
    in_last         = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // directed strings
    send_item(8'h00, 1'b0, 1'b1);          // empty string
    send_string("TWFu", 1'b1);             // full group, empty closing transfer
    send_string("TQ==", 1'b0);             // two leftover sextets, padded
    send_string("/+9", 1'b0);
    send_item(8'hff, 1'b0, 1'b0);          // empty transfer mid-string
    send_item(8'h00, 1'b1, 1'b0);
    send_item(8'hff, 1'b1, 1'b0);
    send_item(8'h80, 1'b1, 1'b0);
    send_item(8'h7f, 1'b1, 1'b0);
    send_item(CHAR_PAD, 1'b1, 1'b0);
    send_item("A", 1'b1, 1'b1);            // ignored after pad; three leftovers
    send_string("z", 1'b0);                // lone sextet is lost
    hold_until_drained();

    // random strings; first one long enough to overflow
    send_random_string(28);
    while (items_sent < 400) begin
      steady <= (items_sent >= 150 && items_sent < 250);
      if (strings_sent == 25) hold_until_drained();
      if ($urandom_range(99) < 70) send_random_string($urandom_range(12));
      else send_random_string($urandom_range(13, 28));
    end
    steady <= 1'b0;

    hold_until_drained();
    repeat (10) @(posedge clk);
    $display("Sent %0d strings in %0d transfers; checked %0d values, %0d of them overflowed.",
             strings_sent, items_sent, values_checked, overflow_values);
    if (fail_count == 0) $display("base64_to_128bit_decoder_unit: match");
    else $display("base64_to_128bit_decoder_unit: mismatch");
    $finish;
  end

endmodule
